// ----- rtl/atf_pkg.sv -----
// Package for the allocation tracker: field widths, operation codes,
// controller states and default sizes. No dependencies.
`default_nettype none

package atf_pkg;

    // Request and response field widths
    localparam int OP_W       = 3;
    localparam int REQ_SIZE_W = 24;
    localparam int BLOCK_ID_W = 10;
    localparam int BYTES_W    = 35;
    localparam int GAP_CNT_W  = 10;
    localparam int PAD_W      = 13;
    localparam int BLK_SIZE_W = 25;
    localparam int COUNT_W    = 11;

    // Offsets and byte totals wrap at this width
    localparam int OFF_W = BYTES_W;

    // Default sizes
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SIZE_BITS_DEF   = 24;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_DEALLOC = 3'd1,
        OP_REALLOC = 3'd2,
        OP_ANALYZE = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_ALLOC_START,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_ALLOC_WR,
        ST_SCAN,
        ST_GAP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/atf_if.sv -----
// Valid/ready channel interfaces for the allocation tracker requests and
// responses. Depends on atf_pkg for field widths.
`default_nettype none

interface atf_in_if
    import atf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [REQ_SIZE_W-1:0] request_size;
    logic [BLOCK_ID_W-1:0] block_id;

    modport source (output valid, operation, request_size, block_id, input ready);
    modport sink   (input valid, operation, request_size, block_id, output ready);
endinterface

interface atf_out_if
    import atf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [BLOCK_ID_W-1:0] result_id;
    logic                  ok;
    logic [BYTES_W-1:0]    live_bytes;
    logic [BYTES_W-1:0]    freed_bytes;
    logic [BYTES_W-1:0]    gap_bytes;
    logic [BYTES_W-1:0]    largest_gap;
    logic [GAP_CNT_W-1:0]  gap_count;
    logic [PAD_W-1:0]      padding_waste;
    logic [BLK_SIZE_W-1:0] smallest_block;
    logic [BLK_SIZE_W-1:0] average_block;
    logic [COUNT_W-1:0]    live_count;
    logic [COUNT_W-1:0]    freed_count;

    modport source (
        output valid, result_id, ok, live_bytes, freed_bytes, gap_bytes, largest_gap,
               gap_count, padding_waste, smallest_block, average_block, live_count,
               freed_count,
        input  ready
    );
    modport sink (
        input  valid, result_id, ok, live_bytes, freed_bytes, gap_bytes, largest_gap,
               gap_count, padding_waste, smallest_block, average_block, live_count,
               freed_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/atf_mem.sv -----
// Block record table: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module atf_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 60
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write record
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read record into a registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/atf_div.sv -----
// Restoring divider, one quotient bit per cycle, for the average block size.
// No package dependencies.
`default_nettype none

module atf_div #(
    parameter int DIVD_W = 36,
    parameter int DIVS_W = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic                   done,
    output logic      [DIVD_W-1:0] quotient
);

    localparam int CW = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   rem_sub;
    logic              fits;

    // Shift in next dividend bit and try subtracting
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
        fits    = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};
    end

    // Advance one step per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            rem_next = fits ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/allocation_tracker_with_fragmentation.sv -----
// Allocation tracker with fragmentation analysis.
// Channels: in_ch takes one request (operation, request_size, block_id) when
// valid and ready are high; out_ch returns exactly one response per request.
// Block records live in a single-port-read synchronous table (atf_mem); the
// controller reads, modifies and writes it back one access at a time.
// Steps per request:
//   clear, unknown op : dispatch, then the response
//   deallocate        : read, check, write back; no read and no check
//                       when the id is at or above the entry count
//   allocate          : walk back record by record from the end of the
//                       table to the last live one, then write the new one
//   reallocate        : deallocate, then allocate
//   analyze           : repeated passes of the table over the live
//                       blocks; each pass of the table
//                       picks the next live block in offset order, and the
//                       average comes from a bit-serial divider
// One request is worked on at a time; in_ch.ready is high only when idle,
// so the next request can be taken, at the earliest, in the cycle after the response is loaded.
// A finished response waits in the output register while the next request
// is taken; if the receiver stalls with a response still held, the
// controller holds the next response until the register frees up.
// Reset empties the table (entry count and byte totals to zero); no
// clearing pass over the memory is needed.
// Depends on atf_pkg, atf_if, atf_mem, atf_div.
`default_nettype none

module allocation_tracker_with_fragmentation
    import atf_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    atf_in_if.sink   in_ch,
    atf_out_if.source out_ch
);

    localparam int A_W    = $clog2(TABLE_DEPTH);
    localparam int C_W    = $clog2(TABLE_DEPTH + 1);
    localparam int RND_W  = SIZE_BITS + 1;
    localparam int SUM_W  = RND_W + C_W;
    localparam int WORD_W = 1 + OFF_W + SIZE_BITS;

    state_t state_reg, state_next;

    op_t                   op_reg, op_next;
    logic [SIZE_BITS-1:0]  req_reg, req_next;
    logic [BLOCK_ID_W-1:0] id_reg, id_next;
    logic [C_W-1:0]        cnt_reg, cnt_next;
    logic [OFF_W-1:0]      tot_alloc_reg, tot_alloc_next;
    logic [OFF_W-1:0]      tot_freed_reg, tot_freed_next;
    logic                  ok_reg, ok_next;
    logic [C_W-1:0]        new_id_reg, new_id_next;
    logic [C_W-1:0]        walk_reg, walk_next;
    logic [OFF_W-1:0]      place_reg, place_next;
    logic                  pv_reg, pv_next;
    logic [A_W-1:0]        pidx_reg, pidx_next;
    logic                  first_reg, first_next;
    logic                  found_reg, found_next;
    logic                  have_prev_reg, have_prev_next;
    logic                  seen_reg, seen_next;
    logic [OFF_W-1:0]      best_off_reg, best_off_next;
    logic [RND_W-1:0]      best_rnd_reg, best_rnd_next;
    logic [A_W-1:0]        best_idx_reg, best_idx_next;
    logic [OFF_W-1:0]      prev_off_reg, prev_off_next;
    logic [A_W-1:0]        prev_idx_reg, prev_idx_next;
    logic [OFF_W-1:0]      last_end_reg, last_end_next;
    logic [OFF_W-1:0]      gap_sum_reg, gap_sum_next;
    logic [OFF_W-1:0]      gap_max_reg, gap_max_next;
    logic [GAP_CNT_W-1:0]  gap_n_reg, gap_n_next;
    logic [PAD_W-1:0]      pad_reg, pad_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [RND_W-1:0]      small_reg, small_next;
    logic [C_W-1:0]        n_reg, n_next;

    // Response register
    logic                  out_valid_reg, out_valid_next;
    logic [BLOCK_ID_W-1:0] o_id_reg, o_id_next;
    logic                  o_ok_reg, o_ok_next;
    logic [BYTES_W-1:0]    o_live_reg, o_live_next;
    logic [BYTES_W-1:0]    o_freed_reg, o_freed_next;
    logic [BYTES_W-1:0]    o_gsum_reg, o_gsum_next;
    logic [BYTES_W-1:0]    o_gmax_reg, o_gmax_next;
    logic [GAP_CNT_W-1:0]  o_gcnt_reg, o_gcnt_next;
    logic [PAD_W-1:0]      o_pad_reg, o_pad_next;
    logic [BLK_SIZE_W-1:0] o_small_reg, o_small_next;
    logic [BLK_SIZE_W-1:0] o_avg_reg, o_avg_next;
    logic [COUNT_W-1:0]    o_lcnt_reg, o_lcnt_next;
    logic [COUNT_W-1:0]    o_fcnt_reg, o_fcnt_next;

    // Memory port
    logic              mem_we;
    logic [A_W-1:0]    mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [A_W-1:0]    mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic                 rd_freed;
    logic [OFF_W-1:0]     rd_off;
    logic [SIZE_BITS-1:0] rd_req;
    logic [RND_W-1:0]     rd_rnd;
    logic [RND_W-1:0]     req_rnd;

    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    logic id_in_range;
    logic table_full;
    logic scan_last;
    logic out_free;
    logic key_after_prev;
    logic [OFF_W-1:0] gap_val;

    atf_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    atf_div #(
        .DIVD_W (SUM_W),
        .DIVS_W (C_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Decode record and derive conditions
    always_comb
    begin
        rd_freed = mem_rdata[WORD_W-1];
        rd_off   = mem_rdata[OFF_W+SIZE_BITS-1:SIZE_BITS];
        rd_req   = mem_rdata[SIZE_BITS-1:0];
        rd_rnd   = (RND_W'(rd_req) + RND_W'(7)) & ~RND_W'(7);
        req_rnd  = (RND_W'(req_reg) + RND_W'(7)) & ~RND_W'(7);

        id_in_range = (32'(id_reg) < 32'(cnt_reg));
        table_full  = (32'(cnt_reg) >= 32'(TABLE_DEPTH));
        scan_last   = pv_reg && (32'(pidx_reg) + 32'd1 == 32'(cnt_reg));
        out_free    = !out_valid_reg || out_ch.ready;

        key_after_prev = !have_prev_reg || (rd_off > prev_off_reg) ||
                         ((rd_off == prev_off_reg) && (pidx_reg > prev_idx_reg));
        gap_val = best_off_reg - last_end_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority case (op_reg)
                    OP_ALLOC:   state_next = ST_ALLOC_START;
                    OP_DEALLOC: state_next = ST_FREE_RD;
                    OP_REALLOC: state_next = ST_FREE_RD;
                    OP_ANALYZE: state_next = (cnt_reg == '0) ? ST_DIV_GO : ST_SCAN;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_FREE_RD:
            begin
                if (id_in_range)
                begin
                    state_next = ST_FREE_CHK;
                end
                else
                begin
                    state_next = (op_reg == OP_REALLOC) ? ST_ALLOC_START : ST_DONE;
                end
            end
            ST_FREE_CHK:
            begin
                state_next = (op_reg == OP_REALLOC) ? ST_ALLOC_START : ST_DONE;
            end
            ST_ALLOC_START:
            begin
                if (table_full)
                begin
                    state_next = ST_DONE;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ST_ALLOC_WR;
                end
                else
                begin
                    state_next = ST_ALLOC_RD;
                end
            end
            ST_ALLOC_RD:
            begin
                state_next = ST_ALLOC_CHK;
            end
            ST_ALLOC_CHK:
            begin
                if (!rd_freed || walk_reg == '0)
                begin
                    state_next = ST_ALLOC_WR;
                end
                else
                begin
                    state_next = ST_ALLOC_RD;
                end
            end
            ST_ALLOC_WR:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP:
            begin
                state_next = found_reg ? ST_SCAN : ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        op_next        = op_reg;
        req_next       = req_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        tot_alloc_next = tot_alloc_reg;
        tot_freed_next = tot_freed_reg;
        ok_next        = ok_reg;
        new_id_next    = new_id_reg;
        walk_next      = walk_reg;
        place_next     = place_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        first_next     = first_reg;
        found_next     = found_reg;
        have_prev_next = have_prev_reg;
        seen_next      = seen_reg;
        best_off_next  = best_off_reg;
        best_rnd_next  = best_rnd_reg;
        best_idx_next  = best_idx_reg;
        prev_off_next  = prev_off_reg;
        prev_idx_next  = prev_idx_reg;
        last_end_next  = last_end_reg;
        gap_sum_next   = gap_sum_reg;
        gap_max_next   = gap_max_reg;
        gap_n_next     = gap_n_reg;
        pad_next       = pad_reg;
        sum_next       = sum_reg;
        small_next     = small_reg;
        n_next         = n_reg;

        out_valid_next = out_valid_reg && !out_ch.ready;
        o_id_next      = o_id_reg;
        o_ok_next      = o_ok_reg;
        o_live_next    = o_live_reg;
        o_freed_next   = o_freed_reg;
        o_gsum_next    = o_gsum_reg;
        o_gmax_next    = o_gmax_reg;
        o_gcnt_next    = o_gcnt_reg;
        o_pad_next     = o_pad_reg;
        o_small_next   = o_small_reg;
        o_avg_next     = o_avg_reg;
        o_lcnt_next    = o_lcnt_reg;
        o_fcnt_next    = o_fcnt_reg;

        mem_we    = 1'b0;
        mem_waddr = A_W'(id_reg);
        mem_wdata = {1'b1, rd_off, rd_req};
        mem_re    = 1'b0;
        mem_raddr = A_W'(id_reg);
        div_start = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch request
                if (in_ch.valid)
                begin
                    op_next  = op_t'(in_ch.operation);
                    req_next = SIZE_BITS'(in_ch.request_size);
                    id_next  = in_ch.block_id;
                end
            end
            ST_DISPATCH:
            begin
                ok_next        = 1'b0;
                new_id_next    = '0;
                walk_next      = '0;
                pv_next        = 1'b0;
                first_next     = 1'b1;
                found_next     = 1'b0;
                have_prev_next = 1'b0;
                seen_next      = 1'b0;
                last_end_next  = '0;
                gap_sum_next   = '0;
                gap_max_next   = '0;
                gap_n_next     = '0;
                pad_next       = '0;
                sum_next       = '0;
                small_next     = '0;
                n_next         = '0;
                priority case (op_reg)
                    OP_ANALYZE:
                    begin
                        ok_next = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        ok_next        = 1'b1;
                        cnt_next       = '0;
                        tot_alloc_next = '0;
                        tot_freed_next = '0;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_FREE_RD:
            begin
                mem_re    = id_in_range;
                mem_raddr = A_W'(id_reg);
            end
            ST_FREE_CHK:
            begin
                // Mark freed if still live
                ok_next = !rd_freed;
                if (!rd_freed)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = A_W'(id_reg);
                    mem_wdata      = {1'b1, rd_off, rd_req};
                    tot_freed_next = tot_freed_reg + OFF_W'(rd_rnd);
                end
            end
            ST_ALLOC_START:
            begin
                place_next = '0;
                walk_next  = cnt_reg - C_W'(1);
                if (table_full)
                begin
                    ok_next     = 1'b0;
                    new_id_next = '0;
                end
            end
            ST_ALLOC_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = walk_reg[A_W-1:0];
            end
            ST_ALLOC_CHK:
            begin
                // Walk back to the last live record
                if (!rd_freed)
                begin
                    place_next = rd_off + OFF_W'(rd_rnd);
                end
                else if (walk_reg != '0)
                begin
                    walk_next = walk_reg - C_W'(1);
                end
            end
            ST_ALLOC_WR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = cnt_reg[A_W-1:0];
                mem_wdata      = {1'b0, place_reg, req_reg};
                new_id_next    = cnt_reg;
                cnt_next       = cnt_reg + C_W'(1);
                tot_alloc_next = tot_alloc_reg + OFF_W'(req_rnd);
                ok_next        = 1'b1;
            end
            ST_SCAN:
            begin
                // Issue the next table read
                if (walk_reg < cnt_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = walk_reg[A_W-1:0];
                    walk_next = walk_reg + C_W'(1);
                    pv_next   = 1'b1;
                    pidx_next = walk_reg[A_W-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end
                // Pick the smallest key past the previous block
                if (pv_reg && !rd_freed)
                begin
                    if (key_after_prev && (!found_reg || rd_off < best_off_reg))
                    begin
                        found_next    = 1'b1;
                        best_off_next = rd_off;
                        best_rnd_next = rd_rnd;
                        best_idx_next = pidx_reg;
                    end
                    if (first_reg)
                    begin
                        n_next   = n_reg + C_W'(1);
                        sum_next = sum_reg + SUM_W'(rd_rnd);
                        pad_next = pad_reg + PAD_W'(rd_rnd - RND_W'(rd_req));
                        if (n_reg == '0 || rd_rnd < small_reg)
                        begin
                            small_next = rd_rnd;
                        end
                    end
                end
            end
            ST_GAP:
            begin
                // Account the gap before the chosen block, start next pass
                if (found_reg)
                begin
                    if (seen_reg && best_off_reg > last_end_reg)
                    begin
                        gap_sum_next = gap_sum_reg + gap_val;
                        gap_n_next   = gap_n_reg + GAP_CNT_W'(1);
                        if (gap_val > gap_max_reg)
                        begin
                            gap_max_next = gap_val;
                        end
                    end
                    last_end_next  = best_off_reg + OFF_W'(best_rnd_reg);
                    seen_next      = 1'b1;
                    prev_off_next  = best_off_reg;
                    prev_idx_next  = best_idx_reg;
                    have_prev_next = 1'b1;
                end
                first_next = 1'b0;
                found_next = 1'b0;
                walk_next  = '0;
                pv_next    = 1'b0;
            end
            ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
            end
            ST_DONE:
            begin
                // Load response register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_id_next      = BLOCK_ID_W'(new_id_reg);
                    o_ok_next      = ok_reg;
                    o_live_next    = tot_alloc_reg - tot_freed_reg;
                    o_freed_next   = tot_freed_reg;
                    o_gsum_next    = '0;
                    o_gmax_next    = '0;
                    o_gcnt_next    = '0;
                    o_pad_next     = '0;
                    o_small_next   = '0;
                    o_avg_next     = '0;
                    o_lcnt_next    = '0;
                    o_fcnt_next    = '0;
                    if (op_reg == OP_ANALYZE)
                    begin
                        o_gsum_next = gap_sum_reg;
                        o_gmax_next = gap_max_reg;
                        o_gcnt_next = gap_n_reg;
                        o_pad_next  = pad_reg;
                        o_lcnt_next = COUNT_W'(n_reg);
                        o_fcnt_next = COUNT_W'(cnt_reg - n_reg);
                        if (n_reg != '0)
                        begin
                            o_small_next = BLK_SIZE_W'(small_reg);
                            o_avg_next   = BLK_SIZE_W'(div_quo);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_ALLOC;
            req_reg       <= '0;
            id_reg        <= '0;
            cnt_reg       <= '0;
            tot_alloc_reg <= '0;
            tot_freed_reg <= '0;
            ok_reg        <= 1'b0;
            new_id_reg    <= '0;
            walk_reg      <= '0;
            place_reg     <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            seen_reg      <= 1'b0;
            best_off_reg  <= '0;
            best_rnd_reg  <= '0;
            best_idx_reg  <= '0;
            prev_off_reg  <= '0;
            prev_idx_reg  <= '0;
            last_end_reg  <= '0;
            gap_sum_reg   <= '0;
            gap_max_reg   <= '0;
            gap_n_reg     <= '0;
            pad_reg       <= '0;
            sum_reg       <= '0;
            small_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            o_id_reg      <= '0;
            o_ok_reg      <= 1'b0;
            o_live_reg    <= '0;
            o_freed_reg   <= '0;
            o_gsum_reg    <= '0;
            o_gmax_reg    <= '0;
            o_gcnt_reg    <= '0;
            o_pad_reg     <= '0;
            o_small_reg   <= '0;
            o_avg_reg     <= '0;
            o_lcnt_reg    <= '0;
            o_fcnt_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            req_reg       <= req_next;
            id_reg        <= id_next;
            cnt_reg       <= cnt_next;
            tot_alloc_reg <= tot_alloc_next;
            tot_freed_reg <= tot_freed_next;
            ok_reg        <= ok_next;
            new_id_reg    <= new_id_next;
            walk_reg      <= walk_next;
            place_reg     <= place_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            first_reg     <= first_next;
            found_reg     <= found_next;
            have_prev_reg <= have_prev_next;
            seen_reg      <= seen_next;
            best_off_reg  <= best_off_next;
            best_rnd_reg  <= best_rnd_next;
            best_idx_reg  <= best_idx_next;
            prev_off_reg  <= prev_off_next;
            prev_idx_reg  <= prev_idx_next;
            last_end_reg  <= last_end_next;
            gap_sum_reg   <= gap_sum_next;
            gap_max_reg   <= gap_max_next;
            gap_n_reg     <= gap_n_next;
            pad_reg       <= pad_next;
            sum_reg       <= sum_next;
            small_reg     <= small_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            o_id_reg      <= o_id_next;
            o_ok_reg      <= o_ok_next;
            o_live_reg    <= o_live_next;
            o_freed_reg   <= o_freed_next;
            o_gsum_reg    <= o_gsum_next;
            o_gmax_reg    <= o_gmax_next;
            o_gcnt_reg    <= o_gcnt_next;
            o_pad_reg     <= o_pad_next;
            o_small_reg   <= o_small_next;
            o_avg_reg     <= o_avg_next;
            o_lcnt_reg    <= o_lcnt_next;
            o_fcnt_reg    <= o_fcnt_next;
        end
    end

    // Drive channels
    assign in_ch.ready           = (state_reg == ST_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.result_id      = o_id_reg;
    assign out_ch.ok             = o_ok_reg;
    assign out_ch.live_bytes     = o_live_reg;
    assign out_ch.freed_bytes    = o_freed_reg;
    assign out_ch.gap_bytes      = o_gsum_reg;
    assign out_ch.largest_gap    = o_gmax_reg;
    assign out_ch.gap_count      = o_gcnt_reg;
    assign out_ch.padding_waste  = o_pad_reg;
    assign out_ch.smallest_block = o_small_reg;
    assign out_ch.average_block  = o_avg_reg;
    assign out_ch.live_count     = o_lcnt_reg;
    assign out_ch.freed_count    = o_fcnt_reg;

endmodule

`default_nettype wire
